@@ rtl/core/ocp_pkg.sv @@
// shared codes and constants for the order crossover block
// no dependencies; imported by every other file of the block

package ocp_pkg;

    localparam int MODE_BITS   = 2;
    localparam int CUT_BITS    = 6;
    localparam int LEN_BITS    = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // input beat mode codes
    localparam logic [MODE_BITS-1:0] MODE_LOAD_FIRST  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_LOAD_SECOND = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_RUN         = 2'd2;

    // commands passed from front to back
    typedef enum logic [1:0] {
        OP_LOAD_FIRST,
        OP_LOAD_SECOND,
        OP_RUN
    } op_t;

endpackage

@@ rtl/core/ocp_if.sv @@
// valid/ready channel interfaces for input beats and child beats
// depends on ocp_pkg for field widths

interface ocp_in_if
    import ocp_pkg::*;
#(
    parameter int KEY_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [MODE_BITS-1:0] mode;
    logic [KEY_BITS-1:0]  element_key;
    logic [CUT_BITS-1:0]  left_cut;
    logic [CUT_BITS-1:0]  right_cut;

    modport source (output valid, output mode, output element_key,
                    output left_cut, output right_cut, input ready);
    modport sink   (input valid, input mode, input element_key,
                    input left_cut, input right_cut, output ready);
endinterface

interface ocp_out_if
#(
    parameter int KEY_BITS = 16
);
    logic                valid;
    logic                ready;
    logic [KEY_BITS-1:0] child_key;
    logic                slot_empty;
    logic                last;

    modport source (output valid, output child_key, output slot_empty,
                    output last, input ready);
    modport sink   (input valid, input child_key, input slot_empty,
                    input last, output ready);
endinterface

@@ rtl/core/ocp_queue.sv @@
// short command queue between the front and back of the crossover block
// depends on ocp_pkg for the queue depth

module ocp_queue
    import ocp_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0]     entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 do_push, do_pop;

    assign full     = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/ocp_front.sv @@
// front end: accepts input beats, tracks load counts, orders the cuts
// depends on ocp_pkg and ocp_if; feeds commands to ocp_queue

module ocp_front
    import ocp_pkg::*;
#(
    parameter int MAX_LENGTH = 64,
    parameter int KEY_BITS   = 16,
    localparam int IDX_BITS  = $clog2(MAX_LENGTH),
    localparam int CNT_BITS  = $clog2(MAX_LENGTH + 1),
    localparam int CMD_BITS  = $bits(op_t) + KEY_BITS + 2 * IDX_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    ocp_in_if.sink              item_in,
    input  logic [CNT_BITS-1:0] n_len,
    input  logic                q_full,
    output logic                push,
    output logic [CMD_BITS-1:0] push_data
);

    typedef struct packed {
        op_t                 op;
        logic [KEY_BITS-1:0] key;
        logic [IDX_BITS-1:0] idx_a;
        logic [IDX_BITS-1:0] idx_b;
    } cmd_t;

    logic [CNT_BITS-1:0] cnt_a_reg, cnt_a_next;
    logic [CNT_BITS-1:0] cnt_b_reg, cnt_b_next;
    logic                accept;
    cmd_t                cmd;
    logic [CUT_BITS-1:0] lo_cut, hi_cut;
    logic [31:0]         lo_w, hi_w, nm1_w;
    logic [IDX_BITS-1:0] left_idx, right_idx;

    assign item_in.ready = !q_full;
    assign accept        = item_in.valid && !q_full;
    assign push_data     = cmd;

    // order the cuts and clamp them to the last position
    always_comb
    begin
        lo_cut = (item_in.left_cut < item_in.right_cut) ? item_in.left_cut : item_in.right_cut;
        hi_cut = (item_in.left_cut < item_in.right_cut) ? item_in.right_cut : item_in.left_cut;
        lo_w   = 32'(lo_cut);
        hi_w   = 32'(hi_cut);
        nm1_w  = 32'(n_len) - 32'd1;
        if (n_len < CNT_BITS'(2))
        begin
            left_idx  = '0;
            right_idx = '0;
        end
        else
        begin
            left_idx  = IDX_BITS'((lo_w > nm1_w) ? nm1_w : lo_w);
            right_idx = IDX_BITS'((hi_w > nm1_w) ? nm1_w : hi_w);
        end
    end

    always_comb
    begin
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        push       = 1'b0;
        cmd.op     = OP_RUN;
        cmd.key    = item_in.element_key;
        cmd.idx_a  = left_idx;
        cmd.idx_b  = right_idx;
        unique case (item_in.mode)
            MODE_LOAD_FIRST:
            begin
                cmd.op    = OP_LOAD_FIRST;
                cmd.idx_a = cnt_a_reg[IDX_BITS-1:0];
                if (accept && (cnt_a_reg != CNT_BITS'(MAX_LENGTH)))
                begin
                    push       = 1'b1;
                    cnt_a_next = cnt_a_reg + 1'b1;
                end
            end
            MODE_LOAD_SECOND:
            begin
                cmd.op    = OP_LOAD_SECOND;
                cmd.idx_a = cnt_b_reg[IDX_BITS-1:0];
                if (accept && (cnt_b_reg != CNT_BITS'(MAX_LENGTH)))
                begin
                    push       = 1'b1;
                    cnt_b_next = cnt_b_reg + 1'b1;
                end
            end
            MODE_RUN:
            begin
                if (accept)
                begin
                    push       = 1'b1;
                    cnt_a_next = '0;
                    cnt_b_next = '0;
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
        end
        else
        begin
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
        end
    end

endmodule

@@ rtl/core/ocp_back.sv @@
// back end: parent and child memories, segment copy, key scan, child emit
// depends on ocp_pkg and ocp_if; takes commands from ocp_queue

module ocp_back
    import ocp_pkg::*;
#(
    parameter int MAX_LENGTH = 64,
    parameter int KEY_BITS   = 16,
    localparam int IDX_BITS  = $clog2(MAX_LENGTH),
    localparam int CNT_BITS  = $clog2(MAX_LENGTH + 1),
    localparam int CMD_BITS  = $bits(op_t) + KEY_BITS + 2 * IDX_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CNT_BITS-1:0] n_len,
    input  logic                q_empty,
    input  logic [CMD_BITS-1:0] q_data,
    output logic                pop,
    ocp_out_if.source           child_out
);

    typedef struct packed {
        op_t                 op;
        logic [KEY_BITS-1:0] key;
        logic [IDX_BITS-1:0] idx_a;
        logic [IDX_BITS-1:0] idx_b;
    } cmd_t;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SEG_RD   = 3'd1;
    localparam logic [2:0] ST_SEG_WR   = 3'd2;
    localparam logic [2:0] ST_SCAN_RD  = 3'd3;
    localparam logic [2:0] ST_SCAN_CMP = 3'd4;
    localparam logic [2:0] ST_EMIT_RD  = 3'd5;
    localparam logic [2:0] ST_EMIT_OUT = 3'd6;

    logic [KEY_BITS-1:0] mem_a [MAX_LENGTH];
    logic [KEY_BITS-1:0] mem_b [MAX_LENGTH];
    logic [KEY_BITS-1:0] mem_c [MAX_LENGTH];
    logic [KEY_BITS-1:0] a_q, b_q, c_q;

    logic [2:0]          state_reg, state_next;
    logic [IDX_BITS-1:0] ptr_reg, ptr_next;
    logic [IDX_BITS-1:0] src_reg, src_next;
    logic [IDX_BITS-1:0] wr_reg, wr_next;
    logic [IDX_BITS-1:0] left_reg, left_next;
    logic [IDX_BITS-1:0] right_reg, right_next;
    logic [CNT_BITS-1:0] off_reg, off_next;
    logic [CNT_BITS-1:0] j_reg, j_next;
    logic [CNT_BITS-1:0] fill_reg, fill_next;
    logic [CNT_BITS-1:0] free_reg, free_next;

    logic                out_valid_reg, out_valid_next;
    logic [KEY_BITS-1:0] out_key_reg, out_key_next;
    logic                out_empty_reg, out_empty_next;
    logic                out_last_reg, out_last_next;
    logic                load_out;

    cmd_t                cmd;
    logic                a_we, b_we, c_we;
    logic [IDX_BITS-1:0] c_waddr;
    logic [KEY_BITS-1:0] c_wdata;
    logic [CNT_BITS-1:0] seg_len;
    logic [CNT_BITS-1:0] ring_dist;
    logic                slot_filled;
    logic                key_match, placed_now, last_key;

    function automatic logic [IDX_BITS-1:0] wrap_inc(input logic [IDX_BITS-1:0] x,
                                                     input logic [CNT_BITS-1:0] n);
        logic [CNT_BITS-1:0] x1;
        x1 = CNT_BITS'(x) + 1'b1;
        return (x1 == n) ? '0 : x1[IDX_BITS-1:0];
    endfunction

    assign cmd      = cmd_t'(q_data);
    assign pop      = (state_reg == ST_IDLE) && !q_empty;
    assign a_we     = pop && (cmd.op == OP_LOAD_FIRST);
    assign b_we     = pop && (cmd.op == OP_LOAD_SECOND);
    assign seg_len  = CNT_BITS'(cmd.idx_b) - CNT_BITS'(cmd.idx_a) + 1'b1;

    // circular distance from the left cut; filled slots form one run from there
    assign ring_dist   = (ptr_reg >= left_reg) ? (CNT_BITS'(ptr_reg) - CNT_BITS'(left_reg))
                                               : (CNT_BITS'(ptr_reg) + n_len - CNT_BITS'(left_reg));
    assign slot_filled = (ring_dist < fill_reg);
    assign key_match   = (c_q == b_q);
    assign placed_now  = !key_match && ((j_reg + 1'b1) == fill_reg);
    assign last_key    = ((off_reg + 1'b1) == n_len) || (placed_now && (free_reg == CNT_BITS'(1)));
    assign load_out    = (state_reg == ST_EMIT_OUT) && (!out_valid_reg || child_out.ready);

    assign child_out.valid      = out_valid_reg;
    assign child_out.child_key  = out_key_reg;
    assign child_out.slot_empty = out_empty_reg;
    assign child_out.last       = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        src_next       = src_reg;
        wr_next        = wr_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        off_next       = off_reg;
        j_next         = j_reg;
        fill_next      = fill_reg;
        free_next      = free_reg;
        c_we           = 1'b0;
        c_waddr        = ptr_reg;
        c_wdata        = a_q;
        out_valid_next = out_valid_reg && !child_out.ready;
        out_key_next   = out_key_reg;
        out_empty_next = out_empty_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop && (cmd.op == OP_RUN) && (n_len != '0))
                begin
                    left_next  = cmd.idx_a;
                    right_next = cmd.idx_b;
                    ptr_next   = cmd.idx_a;
                    fill_next  = seg_len;
                    free_next  = n_len - seg_len;
                    wr_next    = wrap_inc(cmd.idx_b, n_len);
                    src_next   = wrap_inc(cmd.idx_b, n_len);
                    off_next   = '0;
                    state_next = ST_SEG_RD;
                end
            end
            ST_SEG_RD:
            begin
                state_next = ST_SEG_WR;
            end
            ST_SEG_WR:
            begin
                c_we = 1'b1;
                if (ptr_reg == right_reg)
                begin
                    if (free_reg == '0)
                    begin
                        ptr_next   = '0;
                        state_next = ST_EMIT_RD;
                    end
                    else
                    begin
                        ptr_next   = left_reg;
                        j_next     = '0;
                        state_next = ST_SCAN_RD;
                    end
                end
                else
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = ST_SEG_RD;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                if (placed_now)
                begin
                    c_we      = 1'b1;
                    c_waddr   = wr_reg;
                    c_wdata   = b_q;
                    wr_next   = wrap_inc(wr_reg, n_len);
                    fill_next = fill_reg + 1'b1;
                    free_next = free_reg - 1'b1;
                end
                if (key_match || placed_now)
                begin
                    if (last_key)
                    begin
                        ptr_next   = '0;
                        state_next = ST_EMIT_RD;
                    end
                    else
                    begin
                        off_next   = off_reg + 1'b1;
                        src_next   = wrap_inc(src_reg, n_len);
                        ptr_next   = left_reg;
                        j_next     = '0;
                        state_next = ST_SCAN_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    ptr_next   = wrap_inc(ptr_reg, n_len);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_key_next   = slot_filled ? c_q : '0;
                    out_empty_next = !slot_filled;
                    out_last_next  = ((CNT_BITS'(ptr_reg) + 1'b1) == n_len);
                    if ((CNT_BITS'(ptr_reg) + 1'b1) == n_len)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        src_reg       <= src_next;
        wr_reg        <= wr_next;
        left_reg      <= left_next;
        right_reg     <= right_next;
        off_reg       <= off_next;
        j_reg         <= j_next;
        fill_reg      <= fill_next;
        free_reg      <= free_next;
        out_key_reg   <= out_key_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
    end

    // parent and child memories, one write port each, registered reads
    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            mem_a[cmd.idx_a] <= cmd.key;
        end
        if (b_we)
        begin
            mem_b[cmd.idx_a] <= cmd.key;
        end
        if (c_we)
        begin
            mem_c[c_waddr] <= c_wdata;
        end
        a_q <= mem_a[ptr_reg];
        b_q <= mem_b[src_reg];
        c_q <= mem_c[ptr_reg];
    end

endmodule

@@ rtl/core/order_crossover_permutation.sv @@
// order crossover (ox1) of two parent permutations, top level
// load beat: taken one per cycle while the queue is not full, written to its parent memory at
// the edge it leaves the queue (back idle only); the queue holds 4 commands during a run
// run beat: the segment is copied, child entries are compared for each second-parent key
// (until free slots run out), then the child beats are emitted
// reset: control and load counts cleared; parent and child memories hold garbage until written

module order_crossover_permutation
    import ocp_pkg::*;
#(
    parameter int MAX_LENGTH = 64,
    parameter int KEY_BITS   = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [LEN_BITS-1:0] cfg_wdata,
    ocp_in_if.sink              item_in,
    ocp_out_if.source           child_out
);

    localparam int IDX_BITS = $clog2(MAX_LENGTH);
    localparam int CNT_BITS = $clog2(MAX_LENGTH + 1);
    localparam int CMD_BITS = $bits(op_t) + KEY_BITS + 2 * IDX_BITS;

    // element count register; the user must write it only while the block is idle, the block does not enforce it
    logic [LEN_BITS-1:0] length_reg;
    logic [CNT_BITS-1:0] n_len;

    // front to queue to back command path
    logic                q_push, q_pop, q_full, q_empty;
    logic [CMD_BITS-1:0] q_push_data, q_pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
        end
        else if (cfg_we)
        begin
            length_reg <= cfg_wdata;
        end
    end

    // saturate the element count to the memory depth
    assign n_len = (32'(length_reg) > 32'(MAX_LENGTH)) ? CNT_BITS'(MAX_LENGTH)
                                                      : CNT_BITS'(length_reg);

    // front: takes beats, keeps load counts, orders and clamps the cuts
    ocp_front #(
        .MAX_LENGTH (MAX_LENGTH),
        .KEY_BITS   (KEY_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (item_in),
        .n_len     (n_len),
        .q_full    (q_full),
        .push      (q_push),
        .push_data (q_push_data)
    );

    // short command queue so loads keep flowing while a run is busy
    ocp_queue #(
        .WIDTH (CMD_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // back: memories, segment copy, duplicate scan, child beats out
    ocp_back #(
        .MAX_LENGTH (MAX_LENGTH),
        .KEY_BITS   (KEY_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .n_len     (n_len),
        .q_empty   (q_empty),
        .q_data    (q_pop_data),
        .pop       (q_pop),
        .child_out (child_out)
    );

endmodule
